[hdl/fpr_pkg.sv]
//------------------------------------------------------------------------------
// fpr_pkg: shared types and constants of the framed packet receiver
// Holds the frame header bytes, the frame field positions, the result kind
// codes and the result record that travels from the parser to the output.
//------------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

	// Fixed four-byte frame header.
	localparam logic [7:0] HDR_BYTE0 = 8'hAA;
	localparam logic [7:0] HDR_BYTE1 = 8'h55;
	localparam logic [7:0] HDR_BYTE2 = 8'h7F;
	localparam logic [7:0] HDR_BYTE3 = 8'hC0;

	// Response flag in the message code, cleared on output.
	localparam logic [15:0] RESP_BIT = 16'h0080;

	// Byte positions within a frame.
	localparam int unsigned POS_W = 9;
	localparam logic [POS_W-1:0] POS_HDR_END  = 9'd4;
	localparam logic [POS_W-1:0] POS_CODE_HI  = 9'd4;
	localparam logic [POS_W-1:0] POS_CODE_LO  = 9'd5;
	localparam logic [POS_W-1:0] POS_LENGTH   = 9'd6;
	localparam logic [POS_W-1:0] POS_PAYLOAD  = 9'd7;

	// Result kind codes.
	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_SUM_GOOD = 2'd1;
	localparam logic [1:0] KIND_SUM_BAD  = 2'd2;

	// One result item.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [7:0]  payload_index;
		logic [15:0] msg_code;
		logic [7:0]  payload_length;
		logic        frame_end;
	} result_t;

	// Expected header byte at a given header position.
	function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = HDR_BYTE0;
			2'd1:    b = HDR_BYTE1;
			2'd2:    b = HDR_BYTE2;
			2'd3:    b = HDR_BYTE3;
			default: b = HDR_BYTE0;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

[hdl/framed_packet_receiver_sum_check_unit.sv]
//------------------------------------------------------------------------------
// framed_packet_receiver_sum_check_unit: length-prefixed frame receiver
// Hunts for the AA 55 7F C0 header, captures code and length, emits payload
// bytes and closes each frame with a 16-bit additive checksum verdict.
//------------------------------------------------------------------------------
// Usage:
// The slave channel takes one received byte per transaction on s_tdata.
// The master channel delivers payload results (m_tlast low, m_tuser = 0) and
// one frame-end result per frame (m_tlast high, m_tuser = 1 for a good
// checksum, 2 for a bad one). Header, code, length and checksum-high bytes
// produce no result.
// Path: an accepted byte sits in the input register, is decoded from there
// and is loaded into the output register once that register is free, which
// puts its result on the master channel.
// Throughput: one byte per cycle while the output register is free, set by
// the single decode stage between the input register and the output register.
// Reset clears the frame state to the header hunt and empties both registers.
// When m_tready stays low, the held result waits in the output register, one
// more byte waits in the input register, and then s_tready drops.
//------------------------------------------------------------------------------
`default_nettype none

module framed_packet_receiver_sum_check_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [7:0] data_byte, [15:8] payload_index,
	                                    // [31:16] msg_code, [39:32] payload_length
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast    // frame_end
);
	import fpr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       out_free;
	logic       res_valid;
	result_t    res;
	result_t    res_q;

	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Frame decode.
	fpr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register.
	fpr_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.res_in (res),
		.take   (m_tready),
		.free   (out_free),
		.valid  (m_tvalid),
		.res_q  (res_q)
	);

	assign m_tdata = {res_q.payload_length, res_q.msg_code, res_q.payload_index, res_q.data_byte};
	assign m_tuser = res_q.kind;
	assign m_tlast = res_q.frame_end;

	// Checks.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the output register is empty");

	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser != KIND_PAYLOAD)))
		else $error("frame-end flag disagrees with the result kind");

	a_end_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[15:0] == 16'd0))
		else $error("frame-end result carries payload data");

endmodule

`default_nettype wire

[hdl/fpr_parser.sv]
//------------------------------------------------------------------------------
// fpr_parser: frame state and per-byte decode
// Tracks the position within the frame, the running sum, the code and the
// length, and forms at most one result for each byte it is given.
//------------------------------------------------------------------------------
`default_nettype none

module fpr_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic [7:0]       rx_byte,
	output logic                  res_valid,
	output fpr_pkg::result_t      res
);
	import fpr_pkg::*;

	logic [POS_W-1:0] byte_count_q;
	logic [15:0]      running_sum_q;
	logic [7:0]       frame_length_q;
	logic [15:0]      code_word_q;
	logic [7:0]       sum_high_q;

	logic [POS_W-1:0] end_pos;
	logic [POS_W-1:0] idx_full;
	logic [15:0]      sum_next;
	logic [15:0]      got_sum;
	logic             in_header;
	logic             hdr_match;

	assign end_pos   = POS_PAYLOAD + {1'b0, frame_length_q};
	assign idx_full  = byte_count_q - POS_PAYLOAD;
	assign sum_next  = running_sum_q + {8'd0, rx_byte};
	assign got_sum   = {sum_high_q, rx_byte};
	assign in_header = (byte_count_q < POS_HDR_END);
	assign hdr_match = (rx_byte == hdr_byte(byte_count_q[1:0]));

	// Result formation for the byte at the current frame position.
	always_comb begin
		res_valid          = 1'b0;
		res.kind           = KIND_PAYLOAD;
		res.data_byte      = 8'd0;
		res.payload_index  = 8'd0;
		res.msg_code       = code_word_q & ~RESP_BIT;
		res.payload_length = frame_length_q;
		res.frame_end      = 1'b0;
		if (!in_header && byte_count_q >= POS_PAYLOAD) begin
			if (byte_count_q < end_pos) begin
				res_valid         = en;
				res.data_byte     = rx_byte;
				res.payload_index = idx_full[7:0];
			end else if (byte_count_q != end_pos) begin
				res_valid     = en;
				res.kind      = (got_sum == running_sum_q) ? KIND_SUM_GOOD : KIND_SUM_BAD;
				res.frame_end = 1'b1;
			end
		end
	end

	// Frame state update, one byte per enabled cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			running_sum_q  <= '0;
			frame_length_q <= '0;
			code_word_q    <= '0;
			sum_high_q     <= '0;
		end else if (en) begin
			if (in_header) begin
				if (hdr_match) begin
					running_sum_q <= sum_next;
					byte_count_q  <= byte_count_q + 1'b1;
				end else begin
					byte_count_q   <= '0;
					running_sum_q  <= '0;
					frame_length_q <= '0;
					code_word_q    <= '0;
					sum_high_q     <= '0;
				end
			end else if (byte_count_q == POS_CODE_HI) begin
				code_word_q[15:8] <= rx_byte;
				running_sum_q     <= sum_next;
				byte_count_q      <= byte_count_q + 1'b1;
			end else if (byte_count_q == POS_CODE_LO) begin
				code_word_q[7:0] <= rx_byte;
				running_sum_q    <= sum_next;
				byte_count_q     <= byte_count_q + 1'b1;
			end else if (byte_count_q == POS_LENGTH) begin
				frame_length_q <= rx_byte;
				running_sum_q  <= sum_next;
				byte_count_q   <= byte_count_q + 1'b1;
			end else if (byte_count_q < end_pos) begin
				running_sum_q <= sum_next;
				byte_count_q  <= byte_count_q + 1'b1;
			end else if (byte_count_q == end_pos) begin
				sum_high_q   <= rx_byte;
				byte_count_q <= byte_count_q + 1'b1;
			end else begin
				// Checksum low byte closes the frame; hunt again.
				byte_count_q   <= '0;
				running_sum_q  <= '0;
				frame_length_q <= '0;
				code_word_q    <= '0;
				sum_high_q     <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/fpr_out_reg.sv]
//------------------------------------------------------------------------------
// fpr_out_reg: result output register
// Holds one result transaction until the downstream side takes it and reports
// when a new result may be loaded.
//------------------------------------------------------------------------------
`default_nettype none

module fpr_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire fpr_pkg::result_t res_in,
	input  wire logic             take,
	output logic                  free,
	output logic                  valid,
	output fpr_pkg::result_t      res_q
);
	import fpr_pkg::*;

	logic valid_q;

	assign valid = valid_q;
	assign free  = !valid_q || take;

	// Valid flag: set on load, cleared once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

`default_nettype wire
